// ----- hdl/cgbl_pkg.sv -----
// shared types and constants for the click gesture bar display core
`timescale 1ns / 1ps
`default_nettype none

package cgbl_pkg;

    localparam int unsigned BAR_WIDTH_DEFAULT = 8;
    localparam logic [7:0]  TIMEOUT_RESET     = 8'd4;
    localparam logic [7:0]  ELAPSED_MAX       = 8'hFF;

    // gesture table states; 9..15 are unreachable and behave like idle
    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_PRESS1     = 4'd1,
        ST_HOLD1      = 4'd2,
        ST_GAP_SHORT  = 4'd3,
        ST_GAP_LONG   = 4'd4,
        ST_PRESS2_S   = 4'd5,
        ST_HOLD2_S    = 4'd6,
        ST_PRESS2_L   = 4'd7,
        ST_HOLD2_L    = 4'd8
    } state_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_STAMP = 3'd1,
        ACT_SHORT = 3'd2,
        ACT_SS    = 3'd3,
        ACT_SL    = 3'd4,
        ACT_LONG  = 3'd5,
        ACT_LS    = 3'd6,
        ACT_LL    = 3'd7
    } act_t;

    typedef enum logic [2:0] {
        GEST_NONE = 3'd0,
        GEST_S    = 3'd1,
        GEST_SS   = 3'd2,
        GEST_SL   = 3'd3,
        GEST_L    = 3'd4,
        GEST_LS   = 3'd5,
        GEST_LL   = 3'd6
    } gesture_t;

    typedef struct packed {
        state_t     state_next;
        act_t       act;
        logic [7:0] elapsed_next;
    } fsm_out_t;

endpackage

`default_nettype wire

// ----- hdl/cgbl_fsm.sv -----
// gesture table: poll timer, event choice and next state for one item
`timescale 1ns / 1ps
`default_nettype none

module cgbl_fsm (
    input  var cgbl_pkg::state_t   state,
    input  wire logic [7:0]        elapsed_polls,
    input  wire logic [7:0]        timeout_polls,
    input  wire logic              button_pressed,
    output var cgbl_pkg::fsm_out_t result
);

    logic [7:0] elapsed_inc;
    logic       timed;
    logic       timeout;

    always_comb begin
        elapsed_inc = (elapsed_polls == cgbl_pkg::ELAPSED_MAX) ?
                      elapsed_polls : elapsed_polls + 8'd1;
        case (state)
            cgbl_pkg::ST_PRESS1, cgbl_pkg::ST_GAP_SHORT, cgbl_pkg::ST_GAP_LONG,
            cgbl_pkg::ST_PRESS2_S, cgbl_pkg::ST_PRESS2_L: timed = 1'b1;
            default: timed = 1'b0;
        endcase
        timeout = timed && (elapsed_inc >= timeout_polls);

        result.state_next = cgbl_pkg::ST_IDLE;
        result.act        = cgbl_pkg::ACT_NONE;
        case (state)
            cgbl_pkg::ST_PRESS1: begin
                if (timeout) begin
                    result.state_next = cgbl_pkg::ST_HOLD1;
                end else if (button_pressed) begin
                    result.state_next = cgbl_pkg::ST_PRESS1;
                end else begin
                    result.state_next = cgbl_pkg::ST_GAP_SHORT;
                    result.act        = cgbl_pkg::ACT_STAMP;
                end
            end
            cgbl_pkg::ST_HOLD1: begin
                if (button_pressed) begin
                    result.state_next = cgbl_pkg::ST_HOLD1;
                end else begin
                    result.state_next = cgbl_pkg::ST_GAP_LONG;
                    result.act        = cgbl_pkg::ACT_STAMP;
                end
            end
            cgbl_pkg::ST_GAP_SHORT: begin
                if (timeout) begin
                    result.act = cgbl_pkg::ACT_SHORT;
                end else if (button_pressed) begin
                    result.state_next = cgbl_pkg::ST_PRESS2_S;
                    result.act        = cgbl_pkg::ACT_STAMP;
                end else begin
                    result.state_next = cgbl_pkg::ST_GAP_SHORT;
                end
            end
            cgbl_pkg::ST_GAP_LONG: begin
                if (timeout) begin
                    result.act = cgbl_pkg::ACT_LONG;
                end else if (button_pressed) begin
                    result.state_next = cgbl_pkg::ST_PRESS2_L;
                    result.act        = cgbl_pkg::ACT_STAMP;
                end else begin
                    result.state_next = cgbl_pkg::ST_GAP_LONG;
                end
            end
            cgbl_pkg::ST_PRESS2_S: begin
                if (timeout) begin
                    result.state_next = cgbl_pkg::ST_HOLD2_S;
                end else if (button_pressed) begin
                    result.state_next = cgbl_pkg::ST_PRESS2_S;
                end else begin
                    result.act = cgbl_pkg::ACT_SS;
                end
            end
            cgbl_pkg::ST_HOLD2_S: begin
                if (button_pressed) begin
                    result.state_next = cgbl_pkg::ST_HOLD2_S;
                end else begin
                    result.act = cgbl_pkg::ACT_SL;
                end
            end
            cgbl_pkg::ST_PRESS2_L: begin
                if (timeout) begin
                    result.state_next = cgbl_pkg::ST_HOLD2_L;
                end else if (button_pressed) begin
                    result.state_next = cgbl_pkg::ST_PRESS2_L;
                end else begin
                    result.act = cgbl_pkg::ACT_LS;
                end
            end
            cgbl_pkg::ST_HOLD2_L: begin
                if (button_pressed) begin
                    result.state_next = cgbl_pkg::ST_HOLD2_L;
                end else begin
                    result.act = cgbl_pkg::ACT_LL;
                end
            end
            default: begin
                // idle and unreachable codes
                if (button_pressed) begin
                    result.state_next = cgbl_pkg::ST_PRESS1;
                    result.act        = cgbl_pkg::ACT_STAMP;
                end
            end
        endcase

        result.elapsed_next = (result.act == cgbl_pkg::ACT_STAMP) ? 8'd0 : elapsed_inc;
    end

endmodule

`default_nettype wire

// ----- hdl/click_gesture_bar_led_core.sv -----
// top level of the button click gesture decoder driving two bar displays
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+------------------------------------
//  s_        | in        | s_valid / s_ready     | s_button_pressed
//  m_        | out       | m_valid / m_ready     | m_bar1_level, m_bar2_level, m_gesture
//  cfg_      | in        | cfg_valid / cfg_ready | cfg_timeout_polls
//
//  one item per clock unless the result stalls: the whole table step for an item is
//  combinational logic, from the state registers back into themselves and into the result register
//  s_ready is high whenever the result register is empty or is being taken
//  a stalled result holds the input side off; no item is ever dropped
//  reset (aresetn low, synchronous) returns to idle, timeout 4, both bars empty
//  cfg_ready is always high; the timeout register takes effect on the next item
`timescale 1ns / 1ps
`default_nettype none

module click_gesture_bar_led_core #(
    parameter int unsigned BAR_WIDTH = cgbl_pkg::BAR_WIDTH_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output wire logic       s_ready,
    input  wire logic       s_button_pressed,

    output wire logic       m_valid,
    input  wire logic       m_ready,
    output wire logic [7:0] m_bar1_level,
    output wire logic [7:0] m_bar2_level,
    output wire logic [2:0] m_gesture,

    input  wire logic       cfg_valid,
    output wire logic       cfg_ready,
    input  wire logic [7:0] cfg_timeout_polls
);

    // display width is at least the 8-bit level fields
    localparam int unsigned ExtW = (BAR_WIDTH > 8) ? BAR_WIDTH : 8;
    localparam logic [BAR_WIDTH-1:0] BarFull = {BAR_WIDTH{1'b1}};
    localparam logic [BAR_WIDTH-1:0] BarTop  = BarFull ^ (BarFull >> 1);
    localparam logic [BAR_WIDTH-1:0] BarFc   = BarFull & ~BAR_WIDTH'(3);

    // control and pattern state
    cgbl_pkg::state_t    state_reg;
    logic [7:0]          elapsed_reg;
    logic [7:0]          timeout_reg;
    logic [BAR_WIDTH-1:0] bar1_reg, bar1_next;
    logic [BAR_WIDTH-1:0] bar2_reg, bar2_next;

    // result register: bars are shown straight from bar1_reg / bar2_reg,
    // which only move on an accepted item
    logic                 m_valid_reg;
    cgbl_pkg::gesture_t   gesture_reg, gesture_next;

    cgbl_pkg::fsm_out_t   step;
    logic                 s_accept;

    logic [ExtW-1:0]      bar1_ext;
    logic [ExtW-1:0]      bar2_ext;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    cgbl_fsm u_fsm (
        .state          (state_reg),
        .elapsed_polls  (elapsed_reg),
        .timeout_polls  (timeout_reg),
        .button_pressed (s_button_pressed),
        .result         (step)
    );

    // bar actions for the fired gesture
    always_comb begin
        bar1_next    = bar1_reg;
        bar2_next    = bar2_reg;
        gesture_next = cgbl_pkg::GEST_NONE;
        case (step.act)
            cgbl_pkg::ACT_SHORT: begin
                // fill bar1 from the top, then bar2
                if (bar1_reg != BarFull) begin
                    bar1_next = (bar1_reg >> 1) | BarTop;
                end else begin
                    bar2_next = (bar2_reg >> 1) | BarTop;
                end
                gesture_next = cgbl_pkg::GEST_S;
            end
            cgbl_pkg::ACT_SS: begin
                // empty bar2 first, then bar1
                if (bar2_reg != '0) begin
                    bar2_next = bar2_reg << 1;
                end else begin
                    bar1_next = bar1_reg << 1;
                end
                gesture_next = cgbl_pkg::GEST_SS;
            end
            cgbl_pkg::ACT_SL: begin
                bar1_next    = BarFc;
                bar2_next    = '0;
                gesture_next = cgbl_pkg::GEST_SL;
            end
            cgbl_pkg::ACT_LONG: begin
                bar1_next    = BarFull;
                bar2_next    = '0;
                gesture_next = cgbl_pkg::GEST_L;
            end
            cgbl_pkg::ACT_LS: begin
                bar1_next    = BarFull;
                bar2_next    = BarFull;
                gesture_next = cgbl_pkg::GEST_LS;
            end
            cgbl_pkg::ACT_LL: begin
                bar1_next    = '0;
                bar2_next    = '0;
                gesture_next = cgbl_pkg::GEST_LL;
            end
            default: begin
                // no action or time stamp only
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cgbl_pkg::ST_IDLE;
            elapsed_reg <= '0;
            timeout_reg <= cgbl_pkg::TIMEOUT_RESET;
            bar1_reg    <= '0;
            bar2_reg    <= '0;
            m_valid_reg <= 1'b0;
            gesture_reg <= cgbl_pkg::GEST_NONE;
        end else begin
            if (cfg_valid) begin
                timeout_reg <= cfg_timeout_polls;
            end
            if (s_accept) begin
                state_reg   <= step.state_next;
                elapsed_reg <= step.elapsed_next;
                bar1_reg    <= bar1_next;
                bar2_reg    <= bar2_next;
                gesture_reg <= gesture_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // low 8 bits of each pattern, zero extended for narrow bars
    assign bar1_ext     = ExtW'(bar1_reg);
    assign bar2_ext     = ExtW'(bar2_reg);
    assign m_bar1_level = bar1_ext[7:0];
    assign m_bar2_level = bar2_ext[7:0];
    assign m_gesture    = gesture_reg;
    assign m_valid      = m_valid_reg;

`ifndef ASSERT_OFF
    // a fired gesture always ends the sequence back in idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (gesture_reg == cgbl_pkg::GEST_NONE || state_reg == cgbl_pkg::ST_IDLE))
        else $error("gesture fired without return to idle");

    // poll timer either restarts or counts up by one with saturation
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (elapsed_reg == 8'd0 ||
                      elapsed_reg == (($past(elapsed_reg) == cgbl_pkg::ELAPSED_MAX) ?
                                      cgbl_pkg::ELAPSED_MAX : $past(elapsed_reg) + 8'd1)))
        else $error("poll timer skipped a count");

    // a long press leaves bar1 full and bar2 empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && gesture_reg == cgbl_pkg::GEST_L) |->
            (bar1_reg == BarFull && bar2_reg == '0))
        else $error("long gesture with wrong bar patterns");

    // state and bars move only with an accepted item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> ($stable(state_reg) && $stable(bar1_reg) && $stable(bar2_reg)))
        else $error("state changed without an item");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// self-checking testbench for the click gesture bar display core
`timescale 1ns / 1ps

module tb_top;

    localparam int BAR_W         = cgbl_pkg::BAR_WIDTH_DEFAULT;
    localparam int CLK_PERIOD    = 10;
    localparam int LIMIT_NS      = 3_000_000;
    localparam int LONG_HOLD     = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int N_DIR         = 34;
    localparam int N_PHASE       = 7;
    localparam int RND_PHASE     = 5;

    typedef enum logic [1:0] {
        EV_PRESS,
        EV_RELEASE,
        EV_TIMEOUT
    } btn_event_t;

    typedef struct packed {
        cgbl_pkg::state_t nxt;
        cgbl_pkg::act_t   act;
    } move_t;

    typedef struct packed {
        logic [7:0]         bar1;
        logic [7:0]         bar2;
        cgbl_pkg::gesture_t gest;
    } disp_t;

    typedef struct {
        bit    btn;
        bit    typed;
        disp_t lit;
    } dir_row_t;

    localparam disp_t NO_LIT = '{8'h00, 8'h00, cgbl_pkg::GEST_NONE};

    logic       aclk              = 1'b0;
    logic       aresetn           = 1'b0;
    logic       s_valid           = 1'b0;
    logic       s_button_pressed  = 1'b0;
    logic       m_ready           = 1'b1;
    logic       cfg_valid         = 1'b0;
    logic [7:0] cfg_timeout_polls = cgbl_pkg::TIMEOUT_RESET;
    logic       s_ready;
    logic       m_valid;
    logic       cfg_ready;
    logic [7:0] m_bar1_level;
    logic [7:0] m_bar2_level;
    logic [2:0] m_gesture;

    // gesture decoder shadow state
    cgbl_pkg::state_t gs_state;
    logic [7:0]       gs_elapsed;
    logic [BAR_W-1:0] gs_bar1;
    logic [BAR_W-1:0] gs_bar2;
    logic [7:0]       gs_timeout;

    disp_t    bar_pending_q[$];
    dir_row_t dir_tab [N_DIR];
    int       err_cnt     = 0;
    int       items_sent  = 0;
    bit       tx_quiet    = 1'b0;
    bit       rx_quiet    = 1'b0;
    bit       squeeze_req = 1'b0;

    logic [7:0] ph_tmo   [N_PHASE] = '{8'd3, 8'd1, 8'd0, 8'd255, 8'd6, 8'd2,
                                       cgbl_pkg::TIMEOUT_RESET};
    int         ph_items [N_PHASE] = '{200, 120, 80, 500, 150, 150, 200};

    click_gesture_bar_led_core #(
        .BAR_WIDTH(BAR_W)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_button_pressed  (s_button_pressed),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_bar1_level      (m_bar1_level),
        .m_bar2_level      (m_bar2_level),
        .m_gesture         (m_gesture),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_timeout_polls (cfg_timeout_polls)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // states in which the poll counter can force a timeout
    function automatic bit timing_state(cgbl_pkg::state_t st);
        case (st)
            cgbl_pkg::ST_PRESS1, cgbl_pkg::ST_GAP_SHORT, cgbl_pkg::ST_GAP_LONG,
            cgbl_pkg::ST_PRESS2_S, cgbl_pkg::ST_PRESS2_L: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic move_t table_move(cgbl_pkg::state_t st, btn_event_t ev);
        move_t mv;
        mv = '{cgbl_pkg::ST_IDLE, cgbl_pkg::ACT_NONE};
        case (st)
            cgbl_pkg::ST_PRESS1: begin
                if (ev == EV_PRESS) mv = '{cgbl_pkg::ST_PRESS1, cgbl_pkg::ACT_NONE};
                else if (ev == EV_RELEASE) mv = '{cgbl_pkg::ST_GAP_SHORT, cgbl_pkg::ACT_STAMP};
                else mv = '{cgbl_pkg::ST_HOLD1, cgbl_pkg::ACT_NONE};
            end
            cgbl_pkg::ST_HOLD1: begin
                if (ev == EV_PRESS) mv = '{cgbl_pkg::ST_HOLD1, cgbl_pkg::ACT_NONE};
                else if (ev == EV_RELEASE) mv = '{cgbl_pkg::ST_GAP_LONG, cgbl_pkg::ACT_STAMP};
            end
            cgbl_pkg::ST_GAP_SHORT: begin
                if (ev == EV_PRESS) mv = '{cgbl_pkg::ST_PRESS2_S, cgbl_pkg::ACT_STAMP};
                else if (ev == EV_RELEASE) mv = '{cgbl_pkg::ST_GAP_SHORT, cgbl_pkg::ACT_NONE};
                else mv = '{cgbl_pkg::ST_IDLE, cgbl_pkg::ACT_SHORT};
            end
            cgbl_pkg::ST_GAP_LONG: begin
                if (ev == EV_PRESS) mv = '{cgbl_pkg::ST_PRESS2_L, cgbl_pkg::ACT_STAMP};
                else if (ev == EV_RELEASE) mv = '{cgbl_pkg::ST_GAP_LONG, cgbl_pkg::ACT_NONE};
                else mv = '{cgbl_pkg::ST_IDLE, cgbl_pkg::ACT_LONG};
            end
            cgbl_pkg::ST_PRESS2_S: begin
                if (ev == EV_PRESS) mv = '{cgbl_pkg::ST_PRESS2_S, cgbl_pkg::ACT_NONE};
                else if (ev == EV_RELEASE) mv = '{cgbl_pkg::ST_IDLE, cgbl_pkg::ACT_SS};
                else mv = '{cgbl_pkg::ST_HOLD2_S, cgbl_pkg::ACT_NONE};
            end
            cgbl_pkg::ST_HOLD2_S: begin
                if (ev == EV_PRESS) mv = '{cgbl_pkg::ST_HOLD2_S, cgbl_pkg::ACT_NONE};
                else if (ev == EV_RELEASE) mv = '{cgbl_pkg::ST_IDLE, cgbl_pkg::ACT_SL};
            end
            cgbl_pkg::ST_PRESS2_L: begin
                if (ev == EV_PRESS) mv = '{cgbl_pkg::ST_PRESS2_L, cgbl_pkg::ACT_NONE};
                else if (ev == EV_RELEASE) mv = '{cgbl_pkg::ST_IDLE, cgbl_pkg::ACT_LS};
                else mv = '{cgbl_pkg::ST_HOLD2_L, cgbl_pkg::ACT_NONE};
            end
            cgbl_pkg::ST_HOLD2_L: begin
                if (ev == EV_PRESS) mv = '{cgbl_pkg::ST_HOLD2_L, cgbl_pkg::ACT_NONE};
                else if (ev == EV_RELEASE) mv = '{cgbl_pkg::ST_IDLE, cgbl_pkg::ACT_LL};
            end
            // idle, and any unused code behaves the same
            default: begin
                if (ev == EV_PRESS) mv = '{cgbl_pkg::ST_PRESS1, cgbl_pkg::ACT_STAMP};
            end
        endcase
        return mv;
    endfunction

    // one poll through the gesture table, returns the bar display item it causes
    function automatic disp_t gesture_step(bit btn);
        btn_event_t       ev;
        move_t            mv;
        disp_t            d;
        logic [BAR_W-1:0] full;
        full = '1;
        if (gs_elapsed != cgbl_pkg::ELAPSED_MAX) gs_elapsed = gs_elapsed + 8'd1;
        if (timing_state(gs_state) && gs_elapsed >= gs_timeout) ev = EV_TIMEOUT;
        else ev = btn ? EV_PRESS : EV_RELEASE;
        mv = table_move(gs_state, ev);
        d.gest = cgbl_pkg::GEST_NONE;
        case (mv.act)
            cgbl_pkg::ACT_STAMP: gs_elapsed = '0;
            cgbl_pkg::ACT_SHORT: begin
                // fill bar1 from the top, spill into bar2 once full
                if (gs_bar1 != full) gs_bar1 = {1'b1, gs_bar1[BAR_W-1:1]};
                else gs_bar2 = {1'b1, gs_bar2[BAR_W-1:1]};
                d.gest = cgbl_pkg::GEST_S;
            end
            cgbl_pkg::ACT_SS: begin
                // empty bar2 first, then bar1
                if (gs_bar2 != '0) gs_bar2 = gs_bar2 << 1;
                else gs_bar1 = gs_bar1 << 1;
                d.gest = cgbl_pkg::GEST_SS;
            end
            cgbl_pkg::ACT_SL: begin
                gs_bar1 = {{(BAR_W - 2){1'b1}}, 2'b00};
                gs_bar2 = '0;
                d.gest  = cgbl_pkg::GEST_SL;
            end
            cgbl_pkg::ACT_LONG: begin
                gs_bar1 = full;
                gs_bar2 = '0;
                d.gest  = cgbl_pkg::GEST_L;
            end
            cgbl_pkg::ACT_LS: begin
                gs_bar1 = full;
                gs_bar2 = full;
                d.gest  = cgbl_pkg::GEST_LS;
            end
            cgbl_pkg::ACT_LL: begin
                gs_bar1 = '0;
                gs_bar2 = '0;
                d.gest  = cgbl_pkg::GEST_LL;
            end
            default: ;
        endcase
        gs_state = mv.nxt;
        d.bar1 = 8'(gs_bar1);
        d.bar2 = 8'(gs_bar2);
        return d;
    endfunction

    // offer one button sample, predict its display item once accepted
    task automatic send_item(bit btn, bit typed, disp_t lit);
        disp_t pred;
        @(negedge aclk);
        if (!tx_quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_button_pressed <= btn;
        do @(posedge aclk); while (!s_ready);
        pred = gesture_step(btn);
        bar_pending_q.push_back(typed ? lit : pred);
        items_sent++;
    endtask

    task automatic send_run(bit lvl, int len);
        repeat (len) send_item(lvl, 1'b0, NO_LIT);
    endtask

    // run length for a press or gap, short ones often right below the limit
    function automatic int hold_len(int tmo, bit lng);
        if (lng) return (tmo < 1) ? $urandom_range(1, 3) : $urandom_range(tmo, tmo + 2);
        if (tmo <= 2) return 1;
        if ($urandom_range(0, 2) == 0) return tmo - 1;
        return $urandom_range(1, tmo - 1);
    endfunction

    // mostly click shaped sequences, some noise and some cut off early
    task automatic send_burst(int tmo);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            repeat ($urandom_range(1, 6)) send_item(1'($urandom_range(0, 1)), 1'b0, NO_LIT);
        end else begin
            send_run(1'b1, hold_len(tmo, 1'($urandom_range(0, 1))));
            send_run(1'b0, hold_len(tmo, 1'($urandom_range(0, 1))));
            if (kind < 7) send_run(1'b1, hold_len(tmo, 1'($urandom_range(0, 1))));
            // long release tail lets the table settle back to idle
            if (kind != 9) send_run(1'b0, hold_len(tmo, 1'b1) + 1);
        end
    endtask

    // stop offering and wait until every predicted item came out
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (bar_pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(logic [7:0] v);
        @(negedge aclk);
        cfg_valid         <= 1'b1;
        cfg_timeout_polls <= v;
        do @(posedge aclk); while (!cfg_ready);
        gs_timeout = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int idx);
        int         target;
        logic [7:0] tmo;
        drain_results();
        tmo = ph_tmo[idx];
        if (idx == RND_PHASE) tmo = 8'($urandom_range(2, 12));
        write_timeout(tmo);
        // last phase runs flat out on both sides
        tx_quiet = (idx == N_PHASE - 1) || ($urandom_range(0, 3) == 0);
        rx_quiet = (idx == N_PHASE - 1) || ($urandom_range(0, 3) == 0);
        if (idx == 1 || idx == 4) begin
            tx_quiet    = 1'b1;
            squeeze_req = 1'b1;
        end
        target = items_sent + ph_items[idx];
        while (items_sent < target) send_burst(int'(tmo));
    endtask

    // receiver side: random stall bursts plus one long hold on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold_left   = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 9);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        disp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (bar_pending_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result item: bar1 %02h bar2 %02h gesture %0d",
                             m_bar1_level, m_bar2_level, m_gesture);
            end else begin
                want = bar_pending_q.pop_front();
                if (m_bar1_level !== want.bar1 || m_bar2_level !== want.bar2 ||
                    m_gesture !== want.gest) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: want bar1 %02h bar2 %02h gesture %0d, %s %02h %02h %0d",
                                 want.bar1, want.bar2, want.gest, "got",
                                 m_bar1_level, m_bar2_level, m_gesture);
                end
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        gs_state   = cgbl_pkg::ST_IDLE;
        gs_elapsed = '0;
        gs_bar1    = '0;
        gs_bar2    = '0;
        gs_timeout = cgbl_pkg::TIMEOUT_RESET;

        // directed walk at a timeout of two polls, one of each gesture
        dir_tab = '{
            // long
            '{1'b1, 1'b1, '{8'h00, 8'h00, cgbl_pkg::GEST_NONE}},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b0, 1'b0, NO_LIT},
            '{1'b0, 1'b0, NO_LIT},
            '{1'b0, 1'b1, '{8'hFF, 8'h00, cgbl_pkg::GEST_L}},
            // short, spills into bar2
            '{1'b1, 1'b0, NO_LIT},
            '{1'b0, 1'b0, NO_LIT},
            '{1'b0, 1'b0, NO_LIT},
            '{1'b0, 1'b0, NO_LIT},
            // short-short, empties bar2
            '{1'b1, 1'b0, NO_LIT},
            '{1'b0, 1'b0, NO_LIT},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b0, 1'b0, NO_LIT},
            // short-long
            '{1'b1, 1'b0, NO_LIT},
            '{1'b0, 1'b0, NO_LIT},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b0, 1'b1, '{8'hFC, 8'h00, cgbl_pkg::GEST_SL}},
            // long-short
            '{1'b1, 1'b0, NO_LIT},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b0, 1'b0, NO_LIT},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b0, 1'b1, '{8'hFF, 8'hFF, cgbl_pkg::GEST_LS}},
            // long-long
            '{1'b1, 1'b0, NO_LIT},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b0, 1'b0, NO_LIT},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b1, 1'b0, NO_LIT},
            '{1'b0, 1'b1, '{8'h00, 8'h00, cgbl_pkg::GEST_LL}}
        };

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        write_timeout(8'd2);
        foreach (dir_tab[i]) send_item(dir_tab[i].btn, dir_tab[i].typed, dir_tab[i].lit);

        for (int p = 0; p < N_PHASE; p++) run_phase(p);
        drain_results();

        if (err_cnt == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
